// File: hdl/crispr_pam_site_scanner_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros shared by the PAM site scanner RTL.
// ----------------------------------------------------------------------------
`ifndef CRISPR_PAM_SITE_SCANNER_DEFINES_SVH
`define CRISPR_PAM_SITE_SCANNER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CPSS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CPSS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/cpss_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cpss_pkg
// Base codes, character constants and cell control type for the scanner.
// ----------------------------------------------------------------------------
package cpss_pkg;

    // Window entry: bit 2 marks a non-ACGT base, bits 1..0 hold the base code.
    typedef logic [2:0] entry_t;

    localparam entry_t BASE_A   = 3'b000;
    localparam entry_t BASE_C   = 3'b001;
    localparam entry_t BASE_G   = 3'b010;
    localparam entry_t BASE_T   = 3'b011;
    localparam entry_t BASE_BAD = 3'b100;

    // Character bytes recognized by the encoder.
    localparam logic [7:0] CHAR_A     = 8'h41;
    localparam logic [7:0] CHAR_C     = 8'h43;
    localparam logic [7:0] CHAR_G     = 8'h47;
    localparam logic [7:0] CHAR_T     = 8'h54;
    localparam logic [7:0] CHAR_LOW_A = 8'h61;
    localparam logic [7:0] CHAR_LOW_Z = 8'h7A;
    localparam logic [7:0] CASE_DIFF  = 8'h20;

    // Per-cycle control given to each window cell.
    typedef struct packed {
        logic shift;
        logic clear;
    } cell_ctrl_t;

endpackage
`default_nettype wire

// File: hdl/crispr_pam_site_scanner.sv
// ----------------------------------------------------------------------------
// crispr_pam_site_scanner: guide sites next to NGG/NAG PAMs on both strands.
// Result path: the pending stage, then the output register.
// Throughput: one base per cycle; a double hit or out_stall can raise in_stall.
// Reset: window cells read as non-ACGT, position zero, pam_mode zero.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "crispr_pam_site_scanner_defines.svh"
module crispr_pam_site_scanner #(
    parameter int GUIDE_LEN = 20,
    parameter int POS_BITS  = 28
) (
    input  wire                      clk,
    input  wire                      rst_n,
    input  wire                      cfg_wr_en,
    input  wire                      cfg_wr_data,
    input  wire                      in_valid,
    output logic                     in_stall,
    input  wire  [7:0]               base_char,
    input  wire                      seq_start,
    output logic                     out_valid,
    input  wire                      out_stall,
    output logic [2*GUIDE_LEN-1:0]   guide_code,
    output logic [POS_BITS-1:0]      guide_pos,
    output logic                     reverse_strand,
    output logic                     last_of_run
);

    localparam int WIN_LEN  = GUIDE_LEN + 3;
    localparam int CODE_W   = 2 * GUIDE_LEN;
    localparam int REV_BASE = 3;

    // Fold lower case and map a byte onto a window entry.
    function automatic cpss_pkg::entry_t encode_base(input logic [7:0] ch);
        logic [7:0]       up;
        cpss_pkg::entry_t code;
        up = ch;
        if (ch >= cpss_pkg::CHAR_LOW_A && ch <= cpss_pkg::CHAR_LOW_Z)
        begin
            up = ch - cpss_pkg::CASE_DIFF;
        end
        unique case (up)
            cpss_pkg::CHAR_A: code = cpss_pkg::BASE_A;
            cpss_pkg::CHAR_C: code = cpss_pkg::BASE_C;
            cpss_pkg::CHAR_G: code = cpss_pkg::BASE_G;
            cpss_pkg::CHAR_T: code = cpss_pkg::BASE_T;
            default:          code = cpss_pkg::BASE_BAD;
        endcase
        return code;
    endfunction

    logic                 pam_mode_reg;
    logic [POS_BITS-1:0]  count_reg;
    logic [POS_BITS-1:0]  count_next;
    logic [POS_BITS-1:0]  pos_k;

    logic                 accept;
    cpss_pkg::cell_ctrl_t cell_ctrl;
    cpss_pkg::cell_ctrl_t top_ctrl;
    cpss_pkg::entry_t     new_entry;
    cpss_pkg::entry_t     win_q [WIN_LEN];
    cpss_pkg::entry_t     win_n [WIN_LEN];

    logic                 rev_hit;
    logic                 fwd_hit;
    logic                 rev_ok;
    logic                 fwd_ok;
    logic [CODE_W-1:0]    rev_code;
    logic [CODE_W-1:0]    fwd_code;
    cpss_pkg::entry_t     alt_rev;
    cpss_pkg::entry_t     alt_fwd;

    // Pending hits of the last base, reverse first.
    logic                 pr_v_reg;
    logic                 pf_v_reg;
    logic                 pr_last_reg;
    logic [CODE_W-1:0]    pr_code_reg;
    logic [CODE_W-1:0]    pf_code_reg;
    logic [POS_BITS-1:0]  pr_pos_reg;
    logic [POS_BITS-1:0]  pf_pos_reg;

    // Output register.
    logic                 out_valid_reg;
    logic [CODE_W-1:0]    out_code_reg;
    logic [POS_BITS-1:0]  out_pos_reg;
    logic                 out_rev_reg;
    logic                 out_last_reg;

    logic                 out_free;
    logic                 p_pop;
    logic                 p_clear;

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pam_mode_reg <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            pam_mode_reg <= cfg_wr_data;
        end
    end

    // Handshake between the pending stage and the output register.
    assign out_free = !out_valid_reg || !out_stall;
    assign p_pop    = (pr_v_reg || pf_v_reg) && out_free;
    assign p_clear  = !(pr_v_reg || pf_v_reg) || (p_pop && !(pr_v_reg && pf_v_reg));
    assign in_stall = !p_clear;
    assign accept   = in_valid && !in_stall;

    // Window chain control and the newest entry.
    assign new_entry       = encode_base(base_char);
    assign cell_ctrl.shift = accept;
    assign cell_ctrl.clear = seq_start;
    assign top_ctrl.shift  = accept;
    assign top_ctrl.clear  = 1'b0;

    generate
        for (genvar i = 0; i < WIN_LEN; i++)
        begin : g_cell
            if (i == WIN_LEN - 1)
            begin : g_top
                cpss_cell u_cell (
                    .clk            (clk),
                    .rst_n          (rst_n),
                    .ctrl           (top_ctrl),
                    .entry_in       (new_entry),
                    .entry_out      (win_q[i]),
                    .entry_next_out (win_n[i])
                );
            end
            else
            begin : g_mid
                cpss_cell u_cell (
                    .clk            (clk),
                    .rst_n          (rst_n),
                    .ctrl           (cell_ctrl),
                    .entry_in       (win_q[i+1]),
                    .entry_out      (win_q[i]),
                    .entry_next_out (win_n[i])
                );
            end
        end
    endgenerate

    // Position counter: a new sequence restarts at zero.
    assign pos_k      = seq_start ? '0 : count_reg;
    assign count_next = pos_k + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (accept)
        begin
            count_reg <= count_next;
        end
    end

    // PAM compares at fixed slots and guide packing on the shifted window.
    assign alt_rev = pam_mode_reg ? cpss_pkg::BASE_T : cpss_pkg::BASE_C;
    assign alt_fwd = pam_mode_reg ? cpss_pkg::BASE_A : cpss_pkg::BASE_G;

    always_comb
    begin
        rev_ok = 1'b1;
        fwd_ok = 1'b1;
        for (int j = 0; j < GUIDE_LEN; j++)
        begin
            rev_ok = rev_ok && !win_n[REV_BASE + j][2];
            fwd_ok = fwd_ok && !win_n[j][2];
            rev_code[2*j +: 2]                 = ~win_n[REV_BASE + j][1:0];
            fwd_code[2*(GUIDE_LEN-1-j) +: 2]   = win_n[j][1:0];
        end
    end

    assign rev_hit = (win_n[0] == cpss_pkg::BASE_C)
                  && (win_n[1] == cpss_pkg::BASE_C || win_n[1] == alt_rev)
                  && rev_ok;
    assign fwd_hit = (win_n[WIN_LEN-1] == cpss_pkg::BASE_G)
                  && (win_n[WIN_LEN-2] == cpss_pkg::BASE_G || win_n[WIN_LEN-2] == alt_fwd)
                  && fwd_ok;

    // Pending stage valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pr_v_reg <= 1'b0;
            pf_v_reg <= 1'b0;
        end
        else if (accept)
        begin
            pr_v_reg <= rev_hit;
            pf_v_reg <= fwd_hit;
        end
        else if (p_pop)
        begin
            if (pr_v_reg)
            begin
                pr_v_reg <= 1'b0;
            end
            else
            begin
                pf_v_reg <= 1'b0;
            end
        end
    end

    // Pending stage payload.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pr_code_reg <= rev_code;
            pf_code_reg <= fwd_code;
            pr_pos_reg  <= pos_k - POS_BITS'(GUIDE_LEN - 1);
            pf_pos_reg  <= pos_k - POS_BITS'(GUIDE_LEN + 2);
            pr_last_reg <= !fwd_hit;
        end
    end

    // Output register valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= pr_v_reg || pf_v_reg;
        end
    end

    // Output register payload, reverse hit ahead of forward hit.
    always_ff @(posedge clk)
    begin
        if (p_pop)
        begin
            if (pr_v_reg)
            begin
                out_code_reg <= pr_code_reg;
                out_pos_reg  <= pr_pos_reg;
                out_rev_reg  <= 1'b1;
                out_last_reg <= pr_last_reg;
            end
            else
            begin
                out_code_reg <= pf_code_reg;
                out_pos_reg  <= pf_pos_reg;
                out_rev_reg  <= 1'b0;
                out_last_reg <= 1'b1;
            end
        end
    end

    assign out_valid      = out_valid_reg;
    assign guide_code     = out_code_reg;
    assign guide_pos      = out_pos_reg;
    assign reverse_strand = out_rev_reg;
    assign last_of_run    = out_last_reg;

    // Checks on the pending stage and result ordering.
    `CPSS_ASSERT_NOW(a_two_pending_stalls, clk, rst_n, pr_v_reg && pf_v_reg, in_stall, "input taken with two hits pending")
    `CPSS_ASSERT_NEXT(a_double_hit_held, clk, rst_n, accept && rev_hit && fwd_hit, pr_v_reg && pf_v_reg, "double hit not captured")
    `CPSS_ASSERT_NEXT(a_no_hit_empty, clk, rst_n, accept && !rev_hit && !fwd_hit, !pr_v_reg && !pf_v_reg, "phantom hit pending")
    `CPSS_ASSERT_NOW(a_fwd_behind_rev, clk, rst_n, out_valid_reg && out_rev_reg && !out_last_reg, pf_v_reg && !pr_v_reg, "forward hit lost behind reverse hit")

endmodule
`default_nettype wire

// File: hdl/cpss_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cpss_cell
// One window slot; on a shift takes its input entry, or BASE_BAD on clear.
// ----------------------------------------------------------------------------
module cpss_cell (
    input  wire                       clk,
    input  wire                       rst_n,
    input  wire cpss_pkg::cell_ctrl_t ctrl,
    input  wire cpss_pkg::entry_t     entry_in,
    output cpss_pkg::entry_t          entry_out,
    output cpss_pkg::entry_t          entry_next_out
);

    cpss_pkg::entry_t entry_reg;
    cpss_pkg::entry_t entry_next;

    // A new sequence empties the slot while the shift still happens.
    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.shift)
        begin
            entry_next = ctrl.clear ? cpss_pkg::BASE_BAD : entry_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_reg <= cpss_pkg::BASE_BAD;
        end
        else
        begin
            entry_reg <= entry_next;
        end
    end

    assign entry_out      = entry_reg;
    assign entry_next_out = entry_next;

endmodule
`default_nettype wire

// File: sim/tb_crispr_pam_site_scanner.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_crispr_pam_site_scanner
// Streams nucleotide bytes into the PAM site scanner and checks every guide
// site it reports. A scoreboard model tracks the base window, the position
// counter and the PAM mode, and predicts the hits of each accepted base.
// Traffic runs in both PAM modes under steady, gapped and stalled flow.
// ----------------------------------------------------------------------------
module tb_crispr_pam_site_scanner;

    localparam int GUIDE_LEN    = 20;
    localparam int POS_BITS     = 28;
    localparam int WIN_LEN      = GUIDE_LEN + 3;
    localparam int DRAIN_CYCLES = 8;
    localparam int IDLE_PCT[4]  = '{0, 50, 0, 17};
    localparam int STALL_PCT[4] = '{0, 0, 50, 17};

    // One reported guide site.
    typedef struct {
        logic [2*GUIDE_LEN-1:0] code;
        logic [POS_BITS-1:0]    pos;
        logic                   rev;
        logic                   last;
    } guide_site_t;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_wr_en;
    logic                   cfg_wr_data;
    logic                   in_valid;
    logic                   in_stall;
    logic [7:0]             base_char;
    logic                   seq_start;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    logic [2*GUIDE_LEN-1:0] guide_code;
    logic [POS_BITS-1:0]    guide_pos;
    logic                   reverse_strand;
    logic                   last_of_run;

    // Scoreboard model state.
    cpss_pkg::entry_t    scan_window [WIN_LEN];
    logic [POS_BITS-1:0] base_index;
    logic                pam_mode_q;
    guide_site_t         sites_due [$];

    int sender_idle_pct    = 0;
    int receiver_stall_pct = 0;
    int bases_sent         = 0;
    int sites_checked      = 0;
    int reverse_checked    = 0;
    int mismatches         = 0;

    crispr_pam_site_scanner #(
        .GUIDE_LEN(GUIDE_LEN),
        .POS_BITS (POS_BITS)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .base_char     (base_char),
        .seq_start     (seq_start),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .guide_code    (guide_code),
        .guide_pos     (guide_pos),
        .reverse_strand(reverse_strand),
        .last_of_run   (last_of_run)
    );

    initial clk = 1'b0;

    always #1 clk = ~clk;

    // Fold lower case and map a byte to its window entry.
    function automatic cpss_pkg::entry_t encode_char(input logic [7:0] ch);
        logic [7:0] up;
        up = ch;
        if (ch >= cpss_pkg::CHAR_LOW_A && ch <= cpss_pkg::CHAR_LOW_Z)
        begin
            up = ch - cpss_pkg::CASE_DIFF;
        end
        case (up)
            cpss_pkg::CHAR_A: return cpss_pkg::BASE_A;
            cpss_pkg::CHAR_C: return cpss_pkg::BASE_C;
            cpss_pkg::CHAR_G: return cpss_pkg::BASE_G;
            cpss_pkg::CHAR_T: return cpss_pkg::BASE_T;
            default:          return cpss_pkg::BASE_BAD;
        endcase
    endfunction

    // Character for a base, upper or lower case at random.
    function automatic logic [7:0] char_for(input cpss_pkg::entry_t e);
        logic [7:0] ch;
        case (e)
            cpss_pkg::BASE_A: ch = cpss_pkg::CHAR_A;
            cpss_pkg::BASE_C: ch = cpss_pkg::CHAR_C;
            cpss_pkg::BASE_G: ch = cpss_pkg::CHAR_G;
            default:          ch = cpss_pkg::CHAR_T;
        endcase
        if ($urandom_range(0, 1) == 1)
        begin
            ch = ch + cpss_pkg::CASE_DIFF;
        end
        return ch;
    endfunction

    function automatic logic [7:0] random_base_char();
        return char_for(cpss_pkg::entry_t'($urandom_range(0, 3)));
    endfunction

    // Any byte that does not fold to A, C, G or T.
    function automatic logic [7:0] bad_char();
        logic [7:0] b;
        do
        begin
            b = 8'($urandom_range(0, 255));
        end
        while (encode_char(b) != cpss_pkg::BASE_BAD);
        return b;
    endfunction

    // True when the GUIDE_LEN window slots from first on are all A/C/G/T.
    function automatic bit guide_clean(input int first);
        for (int j = 0; j < GUIDE_LEN; j++)
        begin
            if (scan_window[first + j] == cpss_pkg::BASE_BAD)
            begin
                return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    task automatic clear_window();
        foreach (scan_window[i])
        begin
            scan_window[i] = cpss_pkg::BASE_BAD;
        end
        base_index = '0;
    endtask

    // Shift one base into the model window and queue the sites it completes.
    task automatic predict_sites(input logic [7:0] ch, input logic start);
        guide_site_t         found [$];
        guide_site_t         s;
        logic [POS_BITS-1:0] k;
        if (start)
        begin
            clear_window();
        end
        for (int i = 0; i < WIN_LEN - 1; i++)
        begin
            scan_window[i] = scan_window[i + 1];
        end
        scan_window[WIN_LEN - 1] = encode_char(ch);
        k = base_index;
        base_index = base_index + 1'b1;

        // Reverse strand: CC, or CT in NAG mode, any base, then the guide,
        // complemented and read backwards.
        if (scan_window[0] == cpss_pkg::BASE_C &&
            (scan_window[1] == cpss_pkg::BASE_C ||
             (pam_mode_q && scan_window[1] == cpss_pkg::BASE_T)) &&
            guide_clean(3))
        begin
            s.code = '0;
            for (int j = GUIDE_LEN - 1; j >= 0; j--)
            begin
                s.code = {s.code[2*GUIDE_LEN-3:0], ~scan_window[3 + j][1:0]};
            end
            s.pos  = k - POS_BITS'(GUIDE_LEN - 1);
            s.rev  = 1'b1;
            s.last = 1'b0;
            found = {found, s};
        end

        // Forward strand: the guide, any base, then GG, or AG in NAG mode.
        if (scan_window[WIN_LEN - 1] == cpss_pkg::BASE_G &&
            (scan_window[WIN_LEN - 2] == cpss_pkg::BASE_G ||
             (pam_mode_q && scan_window[WIN_LEN - 2] == cpss_pkg::BASE_A)) &&
            guide_clean(0))
        begin
            s.code = '0;
            for (int j = 0; j < GUIDE_LEN; j++)
            begin
                s.code = {s.code[2*GUIDE_LEN-3:0], scan_window[j][1:0]};
            end
            s.pos  = k - POS_BITS'(GUIDE_LEN + 2);
            s.rev  = 1'b0;
            s.last = 1'b0;
            found = {found, s};
        end

        if (found.size() > 0)
        begin
            found[found.size() - 1].last = 1'b1;
        end
        foreach (found[i])
        begin
            sites_due = {sites_due, found[i]};
        end
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("MISMATCH at %0t: %s, got %0h, want %0h", $time, what, got, want);
        mismatches++;
    endtask

    // Offer one base, with a random gap first, and hold it until the transfer.
    task automatic send_base(input logic [7:0] ch, input logic start);
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        base_char <= ch;
        seq_start <= start;
        do
        begin
            @(posedge clk);
        end
        while (in_stall);
        predict_sites(ch, start);
        bases_sent++;
    endtask

    // Drop valid, let every expected site arrive, then let the pipe settle.
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (sites_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_pam_mode(input logic mode);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= mode;
        @(posedge clk);
        pam_mode_q = mode;
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    // One random fragment: a forward, reverse or double site, or plain noise,
    // sometimes broken by a bad base and sometimes opening a new sequence.
    task automatic send_fragment();
        logic [7:0] frag [$];
        int         kind;
        int         pick;
        logic       restart;
        kind = $urandom_range(0, 99);
        if (kind < 25)
        begin
            repeat ($urandom_range(1, 8)) frag = {frag, 8'($urandom_range(0, 255))};
        end
        else if (kind < 60)
        begin
            repeat (GUIDE_LEN) frag = {frag, random_base_char()};
            frag = {frag, 8'($urandom_range(0, 255))};
            pick = $urandom_range(0, 9);
            frag = {frag, (pick < 5 ? char_for(cpss_pkg::BASE_G) :
                           pick < 8 ? char_for(cpss_pkg::BASE_A) : random_base_char())};
            frag = {frag, ($urandom_range(0, 9) != 0 ? char_for(cpss_pkg::BASE_G) :
                                                       random_base_char())};
        end
        else if (kind < 85)
        begin
            frag = {frag, ($urandom_range(0, 9) != 0 ? char_for(cpss_pkg::BASE_C) :
                                                       random_base_char())};
            pick = $urandom_range(0, 9);
            frag = {frag, (pick < 5 ? char_for(cpss_pkg::BASE_C) :
                           pick < 8 ? char_for(cpss_pkg::BASE_T) : random_base_char())};
            frag = {frag, 8'($urandom_range(0, 255))};
            repeat (GUIDE_LEN) frag = {frag, random_base_char()};
        end
        else
        begin
            // Both strands hit on the last base; NGG mode takes only CC and GG.
            frag = {frag, char_for(cpss_pkg::BASE_C)};
            frag = {frag, ($urandom_range(0, 1) == 1 ? char_for(cpss_pkg::BASE_C) :
                                                       char_for(cpss_pkg::BASE_T))};
            repeat (GUIDE_LEN - 1) frag = {frag, random_base_char()};
            frag = {frag, ($urandom_range(0, 1) == 1 ? char_for(cpss_pkg::BASE_G) :
                                                       char_for(cpss_pkg::BASE_A))};
            frag = {frag, char_for(cpss_pkg::BASE_G)};
        end

        if ($urandom_range(0, 99) < 15)
        begin
            frag[$urandom_range(0, frag.size() - 1)] = bad_char();
        end
        restart = ($urandom_range(0, 9) == 0);
        foreach (frag[i])
        begin
            send_base(frag[i], (i == 0 && restart) || $urandom_range(0, 99) == 0);
        end
    endtask

    task automatic run_phase(input int idle, input int stall, input int n_bases);
        int target;
        sender_idle_pct    = idle;
        receiver_stall_pct = stall;
        target = bases_sent + n_bases;
        while (bases_sent < target)
        begin
            send_fragment();
        end
        wait_drained();
    endtask

    // Byte extremes, then a mixed-case sequence whose last base completes a
    // reverse CC site and a forward GG site together.
    task automatic test_directed_sites();
        string seq;
        seq = "cCAGTtacGGATCCATGACTAgG";
        set_pam_mode(1'b0);
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        send_base(8'h00, 1'b1);
        send_base(8'hFF, 1'b0);
        for (int i = 0; i < seq.len(); i++)
        begin
            send_base(seq[i], i == 0);
        end
        wait_drained();
    endtask

    // NGG only: an AG PAM or a CT reverse PAM must not hit.
    task automatic test_ngg_sites();
        set_pam_mode(1'b0);
        run_phase(IDLE_PCT[0], STALL_PCT[0], 130);
        run_phase(IDLE_PCT[1], STALL_PCT[1], 130);
    endtask

    // NAG mode adds AG forward and CT reverse PAMs.
    task automatic test_nag_sites();
        set_pam_mode(1'b1);
        run_phase(IDLE_PCT[2], STALL_PCT[2], 130);
        run_phase(IDLE_PCT[3], STALL_PCT[3], 130);
    endtask

    // Flip the mode between bursts while the window keeps its contents.
    task automatic test_mode_changes();
        for (int p = 0; p < 4; p++)
        begin
            set_pam_mode(~p[0]);
            run_phase(IDLE_PCT[p], STALL_PCT[p], 70);
        end
    endtask

    // Receiver back-pressure.
    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(0, 99) < receiver_stall_pct);
    end

    // Compare each result transfer with the oldest expected site.
    always @(posedge clk)
    begin
        guide_site_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (sites_due.size() == 0)
            begin
                report_mismatch("result with no site expected", 64'(guide_code), 64'd0);
            end
            else
            begin
                want = sites_due.pop_front();
                if (guide_code !== want.code)
                begin
                    report_mismatch("guide_code", 64'(guide_code), 64'(want.code));
                end
                if (guide_pos !== want.pos)
                begin
                    report_mismatch("guide_pos", 64'(guide_pos), 64'(want.pos));
                end
                if (reverse_strand !== want.rev)
                begin
                    report_mismatch("reverse_strand", 64'(reverse_strand), 64'(want.rev));
                end
                if (last_of_run !== want.last)
                begin
                    report_mismatch("last_of_run", 64'(last_of_run), 64'(want.last));
                end
                sites_checked++;
                if (want.rev)
                begin
                    reverse_checked++;
                end
            end
        end
    end

    initial
    begin
        rst_n       <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= 1'b0;
        in_valid    <= 1'b0;
        base_char   <= 8'h00;
        seq_start   <= 1'b0;
        clear_window();
        pam_mode_q = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_sites();
        test_ngg_sites();
        test_nag_sites();
        test_mode_changes();

        $display("Sent %0d bases; checked %0d guide sites, %0d of them reverse strand.",
                 bases_sent, sites_checked, reverse_checked);
        $display("Both PAM modes ran under steady flow, sender gaps, receiver stalls and both.");
        if (mismatches == 0)
        begin
            $display("end of test: clean");
        end
        else
        begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // Watchdog far beyond the slowest legal run.
    initial
    begin
        #400000;
        $display("Timeout with %0d sites still expected.", sites_due.size());
        $display("end of test: mismatches");
        $finish;
    end

endmodule

// File: sim.f
+incdir+hdl
hdl/cpss_pkg.sv
hdl/cpss_cell.sv
hdl/crispr_pam_site_scanner.sv
sim/tb_crispr_pam_site_scanner.sv
